### hdl/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER_AT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER_AT(lbl, clk, rst, cond)

`endif

`endif

### hdl/bmhq_pkg.sv
// Types and codes shared by the heap queue modules.
`timescale 1ns / 1ps

package bmhq_pkg;

  // Request kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One heap entry: key in the upper half, tag in the lower half
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] tag;
  } entry_t;

  // Work handed to the sift engine
  typedef struct packed {
    logic   start;
    logic   pop;
    entry_t entry;
  } req_t;

  // Completion from the sift engine
  typedef struct packed {
    logic   done;
    entry_t entry;
  } rsp_t;

endpackage

### hdl/bmhq_engine.sv
// Heap store and sift sequencer built around one shared key comparator.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmhq_engine #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  bmhq_pkg::req_t  req,
  input  logic [AW-1:0]   cnt,    // entries held before this request
  output bmhq_pkg::rsp_t  rsp
);
  import bmhq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_RD    = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_POP_LAST = 9'b000001000,
    S_POP_WAIT = 9'b000010000,
    S_DN_CHK   = 9'b000100000,
    S_DN_RDL   = 9'b001000000,
    S_DN_RDR   = 9'b010000000,
    S_DN_CMP   = 9'b100000000
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] pos, pos_next;      // current slot or hole
  logic [AW:0]   ch, ch_next;        // chosen child during descent
  logic [AW-1:0] nlast, nlast_next;  // entries held after the pop
  entry_t        moved, moved_next;  // entry being sifted
  entry_t        top, top_next;      // popped root
  entry_t        child, child_next;  // smaller child seen so far

  entry_t        mem [DEPTH];
  entry_t        rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic [15:0]   cmp_a, cmp_b;
  logic          lt;
  logic          fin_up, fin_dn;

  // Shared comparator
  assign lt = cmp_a < cmp_b;

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    pos_next   = pos;
    ch_next    = ch;
    nlast_next = nlast;
    moved_next = moved;
    top_next   = top;
    child_next = child;
    rd_en      = 1'b0;
    rd_addr    = pos;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_data    = moved;
    cmp_a      = moved.key;
    cmp_b      = rd_data.key;
    fin_up     = 1'b0;
    fin_dn     = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          if (req.pop == KIND_POP) begin
            rd_en      = 1'b1;
            rd_addr    = AW'(1);
            nlast_next = cnt - AW'(1);
            pos_next   = AW'(1);
            ch_next    = (AW+1)'(2);
            state_next = S_POP_LAST;
          end else begin
            pos_next   = cnt + AW'(1);
            moved_next = req.entry;
            state_next = S_UP_RD;
          end
        end
      end
      S_UP_RD: begin
        if (pos == AW'(1)) begin
          wr_en      = 1'b1;
          fin_up     = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = pos >> 1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // Move the parent down while the new key is smaller
        wr_en = 1'b1;
        if (lt) begin
          wr_data    = rd_data;
          pos_next   = pos >> 1;
          state_next = S_UP_RD;
        end else begin
          fin_up     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP_LAST: begin
        top_next   = rd_data;
        rd_en      = 1'b1;
        rd_addr    = nlast + AW'(1);
        state_next = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        moved_next = rd_data;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (ch > {1'b0, nlast}) begin
          wr_en      = 1'b1;
          fin_dn     = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = ch[AW-1:0];
          state_next = S_DN_RDL;
        end
      end
      S_DN_RDL: begin
        child_next = rd_data;
        if (ch < {1'b0, nlast}) begin
          rd_en      = 1'b1;
          rd_addr    = ch[AW-1:0] + AW'(1);
          state_next = S_DN_RDR;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_RDR: begin
        // Take the right child only when its key is strictly smaller
        cmp_a = rd_data.key;
        cmp_b = child.key;
        if (lt) begin
          child_next = rd_data;
          ch_next    = ch + (AW+1)'(1);
        end
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmp_b = child.key;
        wr_en = 1'b1;
        if (lt) begin
          fin_dn     = 1'b1;
          state_next = S_IDLE;
        end else begin
          wr_data    = child;
          pos_next   = ch[AW-1:0];
          ch_next    = {ch[AW-1:0], 1'b0};
          state_next = S_DN_CHK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= fin_up || fin_dn;
    end
    pos   <= pos_next;
    ch    <= ch_next;
    nlast <= nlast_next;
    moved <= moved_next;
    top   <= top_next;
    child <= child_next;
    if (fin_dn) begin
      rsp.entry <= top;
    end else if (fin_up) begin
      rsp.entry <= '0;
    end
  end

  // A new request arrives only while the sequencer is idle
  `ASSERT_AT(a_start_idle, clk, rst, req.start |-> state == S_IDLE)
  // The chosen child always sits directly below the hole
  `ASSERT_AT(a_child_of_hole, clk, rst, state == S_DN_CMP |-> ch[AW:1] == pos)
  // Sifting never reaches the unused slot zero
  `ASSERT_NEVER_AT(a_no_slot0, clk, rst,
    (state == S_UP_RD || state == S_UP_CMP || state == S_DN_CHK) && pos == '0)

endmodule

### hdl/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue with stream ports.
// Push sifts up from the next free slot, pop sifts down from the root; each result is then
// registered before it loads into the output register; a refused request skips the sift engine.
// One request at a time, the next accepted in the cycle after a result loads; the sift loop
// shares one store read port and one comparator (S_UP_RD, S_UP_CMP up; S_DN_CHK to S_DN_CMP down).
// Reset clears the entry count and all handshake state; the store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_min_heap_queue #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] key, [31:16] tag
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] out_key, [31:16] out_tag, [39:32] count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = (AW > 8) ? AW : 8;

  logic [AW-1:0] count;
  logic [CW-1:0] count_w;
  logic          busy;
  logic          res_valid;
  logic [1:0]    res_status;
  entry_t        res_entry;
  logic          accept;
  logic          kind;
  logic          full, empty;
  logic          refuse;
  logic          load_out;
  req_t          req;
  rsp_t          rsp;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser[0];
  assign full          = count == AW'(CAPACITY - 1);
  assign empty         = count == '0;
  assign refuse        = (kind == KIND_PUSH) ? full : empty;
  assign s_axis_tready = !busy;
  assign load_out      = res_valid && (!m_axis_tvalid || m_axis_tready);
  assign count_w       = CW'(count);

  // Hand accepted work to the sift engine
  assign req.start     = accept && !refuse;
  assign req.pop       = kind;
  assign req.entry.key = s_axis_tdata[15:0];
  assign req.entry.tag = s_axis_tdata[31:16];

  bmhq_engine #(
    .DEPTH (CAPACITY)
  ) u_engine (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cnt (count),
    .rsp (rsp)
  );

  // Track entry count and the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      busy          <= 1'b0;
      res_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (req.start) begin
        count <= (kind == KIND_POP) ? count - AW'(1) : count + AW'(1);
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (load_out) begin
        busy <= 1'b0;
      end
      if ((accept && refuse) || rsp.done) begin
        res_valid <= 1'b1;
      end else if (load_out) begin
        res_valid <= 1'b0;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (accept && refuse) begin
      res_status <= (kind == KIND_PUSH) ? ST_FULL : ST_EMPTY;
      res_entry  <= '0;
    end else if (rsp.done) begin
      res_status <= ST_DONE;
      res_entry  <= rsp.entry;
    end
  end

  // Load the output word; count is already final for this request
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {count_w[7:0], res_entry.tag, res_entry.key};
      m_axis_tuser <= res_status;
    end
  end

  // Accepting a word closes the input until its result moves out
  `ASSERT_AT(a_accept_busy, clk, rst, accept |=> busy && !s_axis_tready)
  // Engine completion never overwrites a pending result
  `ASSERT_AT(a_done_free, clk, rst, rsp.done |-> busy && !res_valid)
  // Count stays within the usable slots
  `ASSERT_AT(a_count_cap, clk, rst, count <= AW'(CAPACITY - 1))

endmodule

### verif/tb_top.sv
// Self-checking testbench for the binary min-heap priority queue.
`timescale 1ns / 1ps

module tb_top;
  import bmhq_pkg::*;

  localparam int HEAP_SLOTS  = 256;
  localparam int MAX_ENTRIES = HEAP_SLOTS - 1;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 80;

  // Random segment shapes
  localparam int SEG_FILL  = 0;
  localparam int SEG_DRAIN = 1;
  localparam int SEG_MIXED = 2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] key;
    logic [15:0] tag;
    logic [7:0]  count;
  } result_t;

  typedef struct {
    logic    kind;
    logic [15:0] key;
    logic [15:0] tag;
    bit      typed;
    result_t want;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] key, [31:16] tag
  logic [0:0]  s_axis_tuser = '0;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [15:0] out_key, [31:16] out_tag, [39:32] count
  logic [1:0]  m_axis_tuser;        // [1:0] status

  // Shadow copy of the heap and the results still owed by the block
  entry_t      heap_mem [0:HEAP_SLOTS-1];
  int unsigned shadow_count = 0;
  result_t     owed_results [$];
  int          mismatches = 0;
  int          sent_items = 0;
  int          gap_odds = 0;
  bit          quiet = 1'b0;

  binary_min_heap_queue #(.CAPACITY(HEAP_SLOTS)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Place a new entry at the next free slot and float it up past larger parents
  function automatic void heap_insert(entry_t e);
    int unsigned pos;
    pos = shadow_count + 1;
    shadow_count = pos;
    while (pos != 1 && e.key < heap_mem[pos / 2].key) begin
      heap_mem[pos] = heap_mem[pos / 2];
      pos = pos / 2;
    end
    heap_mem[pos] = e;
  endfunction

  // Remove the root, move the last entry up and sink it; ties go left
  function automatic entry_t heap_extract();
    entry_t top;
    entry_t moved;
    int unsigned hole;
    int unsigned child;
    top = heap_mem[1];
    moved = heap_mem[shadow_count];
    hole = 1;
    child = 2;
    shadow_count = shadow_count - 1;
    while (child <= shadow_count) begin
      if (child < shadow_count && heap_mem[child].key > heap_mem[child + 1].key)
        child = child + 1;
      if (moved.key < heap_mem[child].key)
        break;
      heap_mem[hole] = heap_mem[child];
      hole = child;
      child = child * 2;
    end
    heap_mem[hole] = moved;
    return top;
  endfunction

  // Work out the result word of one request and advance the shadow heap
  function automatic result_t predict_result(logic kind, logic [15:0] key, logic [15:0] tag);
    result_t r;
    entry_t  e;
    r = '0;
    r.status = ST_DONE;
    if (kind == KIND_PUSH) begin
      if (shadow_count >= MAX_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        e.key = key;
        e.tag = tag;
        heap_insert(e);
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e = heap_extract();
      r.key = e.key;
      r.tag = e.tag;
    end
    r.count = shadow_count[7:0];
    return r;
  endfunction

  // Drive one request word, wait for acceptance, then maybe idle for a burst
  task automatic issue(logic kind, logic [15:0] key, logic [15:0] tag,
                       bit typed, result_t want);
    result_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {tag, key};
    do @(posedge clk); while (!s_axis_tready);
    r = predict_result(kind, key, tag);
    owed_results.push_back(typed ? want : r);
    sent_items++;
    if (!quiet && gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Mix wide keys with a narrow range that forces ties, plus the extremes
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1, 2: return 16'($urandom);
      3, 4:    return 16'($urandom_range(0, 7));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic run_segment(int shape, int len);
    logic    kind;
    int      extra;
    result_t none;
    none = '0;
    gap_odds = quiet ? 0 : $urandom_range(0, 3) * 15;
    extra = $urandom_range(1, 4);
    for (int i = 0; i < len || len == 0; i++) begin
      if (shape == SEG_FILL) begin
        if (shadow_count >= MAX_ENTRIES) begin
          if (extra == 0) break;
          extra--;
        end
        kind = ($urandom_range(0, 9) < 8) ? KIND_PUSH : KIND_POP;
      end else if (shape == SEG_DRAIN) begin
        if (shadow_count == 0) begin
          if (extra == 0) break;
          extra--;
        end
        kind = ($urandom_range(0, 9) < 8) ? KIND_POP : KIND_PUSH;
      end else begin
        kind = $urandom_range(0, 1) ? KIND_POP : KIND_PUSH;
      end
      issue(kind, pick_key(), 16'($urandom), 1'b0, none);
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[39:32]};
      if (owed_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result word status=%0d key=%h tag=%h count=%0d",
                   $realtime, got.status, got.key, got.tag, got.count);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status || got.key !== want.key ||
            got.tag !== want.tag || got.count !== want.count) begin
          if (mismatches < 10)
            $display("%0t: mismatch status %0d/%0d key %h/%h tag %h/%h count %0d/%0d",
                     $realtime, want.status, got.status, want.key, got.key,
                     want.tag, got.tag, want.count, got.count);
          mismatches++;
        end
      end
    end
  end

  // Stall the result side in bursts, with longer ready stretches between
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Directed requests: empty edges, extreme keys and tags, ties
  req_row_t directed [] = '{
    '{KIND_POP,  16'h0000, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 8'd0}},
    '{KIND_PUSH, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd1}},
    '{KIND_POP,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_DONE,  16'hFFFF, 16'hFFFF, 8'd0}},
    '{KIND_POP,  16'hFFFF, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 8'd0}},
    '{KIND_PUSH, 16'h0000, 16'h0000, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd1}},
    '{KIND_PUSH, 16'h0000, 16'h0001, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd2}},
    '{KIND_PUSH, 16'hFFFF, 16'h1234, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd3}},
    '{KIND_PUSH, 16'h8000, 16'hA5A5, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd4}},
    '{KIND_PUSH, 16'h0001, 16'h5A5A, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd5}},
    '{KIND_PUSH, 16'h0001, 16'hFFFE, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd6}},
    '{KIND_PUSH, 16'h7FFF, 16'h8000, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd7}},
    '{KIND_PUSH, 16'h0000, 16'hFFFF, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd8}},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_POP,  16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_PUSH, 16'h0001, 16'h0F0F, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b0, '0},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 8'd0}},
    '{KIND_PUSH, 16'h5555, 16'hAAAA, 1'b1, '{ST_DONE,  16'h0000, 16'h0000, 8'd1}},
    '{KIND_POP,  16'h0000, 16'h0000, 1'b1, '{ST_DONE,  16'h5555, 16'hAAAA, 8'd0}}
  };

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_odds = 30;
    foreach (directed[i])
      issue(directed[i].kind, directed[i].key, directed[i].tag,
            directed[i].typed, directed[i].want);

    // Reach both the full and the empty heap at least once
    run_segment(SEG_FILL, 0);
    run_segment(SEG_DRAIN, 0);
    while (sent_items < RANDOM_ITEMS)
      run_segment($urandom_range(SEG_FILL, SEG_MIXED), $urandom_range(20, 80));

    // Finish with back-to-back traffic on both sides
    quiet = 1'b1;
    run_segment(SEG_MIXED, QUIET_ITEMS);
    s_axis_tvalid <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0)
      $display("binary_min_heap_queue regression: pass");
    else
      $display("binary_min_heap_queue regression: fail");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("binary_min_heap_queue regression: fail");
    $finish;
  end

endmodule
